// ===== sv/acc_ws_pkg.sv =====
package acc_ws_pkg;

  localparam int WINDOW_LEN  = 52;
  localparam int CNT_W       = $clog2(WINDOW_LEN + 1);
  localparam int POS_W       = $clog2(WINDOW_LEN);
  localparam int CMP_W       = (CNT_W + 1 > 6) ? CNT_W + 1 : 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W       = 3;

  localparam logic [IDX_W-1:0] REG_REST_OFFSET    = 3'd0;
  localparam logic [IDX_W-1:0] REG_ACTIVITY_LEVEL = 3'd1;
  localparam logic [IDX_W-1:0] REG_WAKE_COUNT     = 3'd2;
  localparam logic [IDX_W-1:0] REG_BUSY_COUNT     = 3'd3;
  localparam logic [IDX_W-1:0] REG_SLEEP_AFTER    = 3'd4;

  localparam logic [1:0] MODE_SLEEP  = 2'd0;
  localparam logic [1:0] MODE_ACTIVE = 2'd1;
  localparam logic [1:0] MODE_READY  = 2'd2;

  typedef struct packed {
    logic [15:0] rest_offset;
    logic [15:0] activity_level;
    logic [5:0]  wake_count;
    logic [5:0]  busy_count;
    logic [15:0] sleep_after;
  } cfg_t;

  // One classified item as handed from the front end to the mode controller.
  typedef struct packed {
    logic        report;
    logic        nonzero;
    logic        flag;
    logic [15:0] dev;
  } job_t;

endpackage

// ===== sv/accel_activity_wake_sleep_top.sv =====
// Accelerometer activity and inactivity mode detector.
// Input channel (in_valid/in_ready): func selects an xyz sample (0) or a
// client count report (1). Each item yields exactly one result on the output
// channel (out_valid/out_ready): the mode after the item, the magnitude
// deviation, the flagged count of the sliding window and a mode change flag.
// After a sample is accepted, the front end forms the squares, then their sum,
// then the bit-serial square root, and then forms and queues the result; it
// takes the next item only once that result is queued, so it works on one item
// at a time. A client report is queued without these steps. For each item the
// mode controller reads the oldest window flag and then updates its state; it
// takes the next item from the queue only after the result of the last one has
// been loaded into the output register.
// A two-entry queue sits between the front end and the controller, and the
// result sits in an output register; while the receiver stalls, the front
// end keeps accepting and working on items until the queue fills.
// Reset puts the block in sleep mode with an empty window and loads the default
// thresholds. Registers are written through cfg_write, cfg_index and cfg_data;
// the user must write only when no item is in flight; the block does not check.
module accel_activity_wake_sleep_top import acc_ws_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic signed [15:0] acc_x,
  input  logic signed [15:0] acc_y,
  input  logic signed [15:0] acc_z,
  input  logic [7:0]         clients,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         mode,
  output logic [15:0]        deviation,
  output logic [5:0]         window_active,
  output logic               mode_changed,
  input  logic               cfg_write,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t cfg;
  logic push, full, pop, empty;
  job_t push_job, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rest_offset    <= 16'd8234;
      cfg.activity_level <= 16'd100;
      cfg.wake_count     <= 6'd2;
      cfg.busy_count     <= 6'd2;
      cfg.sleep_after    <= 16'd780;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_REST_OFFSET:    cfg.rest_offset    <= cfg_data;
        REG_ACTIVITY_LEVEL: cfg.activity_level <= cfg_data;
        REG_WAKE_COUNT:     cfg.wake_count     <= cfg_data[5:0];
        REG_BUSY_COUNT:     cfg.busy_count     <= cfg_data[5:0];
        REG_SLEEP_AFTER:    cfg.sleep_after    <= cfg_data;
        default: ;
      endcase
    end
  end

  acc_ws_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .acc_x    (acc_x),
    .acc_y    (acc_y),
    .acc_z    (acc_z),
    .clients  (clients),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  acc_ws_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  acc_ws_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .mode          (mode),
    .deviation     (deviation),
    .window_active (window_active),
    .mode_changed  (mode_changed)
  );

endmodule

// ===== sv/acc_ws_front.sv =====
module acc_ws_front import acc_ws_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic signed [15:0] acc_x,
  input  logic signed [15:0] acc_y,
  input  logic signed [15:0] acc_z,
  input  logic [7:0]         clients,
  output logic               push,
  output job_t               push_job,
  input  logic               full
);

  typedef enum logic [5:0] {
    F_IDLE   = 6'b000001,
    F_SQUARE = 6'b000010,
    F_SUM    = 6'b000100,
    F_ROOT   = 6'b001000,
    F_DONE   = 6'b010000,
    F_PUSH   = 6'b100000
  } fstate_t;

  fstate_t     state, state_next;
  logic [15:0] abs_x, abs_y, abs_z;
  logic [31:0] sq_x, sq_y, sq_z;
  logic [31:0] rem, root, bit_mask;
  job_t        job;

  logic [31:0] trial;
  logic [16:0] r_ext, off_ext, r_ceil;
  logic [15:0] dev;

  assign in_ready = (state == F_IDLE);
  assign push     = (state == F_PUSH) && !full;
  assign push_job = job;

  assign trial   = root + bit_mask;
  assign r_ext   = {1'b0, root[15:0]};
  assign off_ext = {1'b0, cfg.rest_offset};
  // Below the offset the root is rounded up unless the sum was a perfect square.
  assign r_ceil  = (rem == 32'd0) ? r_ext : r_ext + 17'd1;
  assign dev     = (r_ext >= off_ext) ? 16'(r_ext - off_ext) : 16'(off_ext - r_ceil);

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (in_valid) begin
          state_next = func ? F_PUSH : F_SQUARE;
        end
      end
      F_SQUARE: state_next = F_SUM;
      F_SUM:    state_next = F_ROOT;
      F_ROOT: begin
        if (bit_mask[0]) begin
          state_next = F_DONE;
        end
      end
      F_DONE: state_next = F_PUSH;
      F_PUSH: begin
        if (!full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (in_valid) begin
          abs_x       <= acc_x[15] ? 16'(-acc_x) : acc_x;
          abs_y       <= acc_y[15] ? 16'(-acc_y) : acc_y;
          abs_z       <= acc_z[15] ? 16'(-acc_z) : acc_z;
          job.report  <= func;
          job.nonzero <= (clients != 8'd0);
          job.flag    <= 1'b0;
          job.dev     <= 16'd0;
        end
      end
      F_SQUARE: begin
        sq_x <= 32'(abs_x) * 32'(abs_x);
        sq_y <= 32'(abs_y) * 32'(abs_y);
        sq_z <= 32'(abs_z) * 32'(abs_z);
      end
      F_SUM: begin
        rem      <= sq_x + sq_y + sq_z;
        root     <= 32'd0;
        bit_mask <= 32'h4000_0000;
      end
      F_ROOT: begin
        // One result bit per cycle, two bits of the radicand consumed.
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + bit_mask;
        end else begin
          root <= root >> 1;
        end
        bit_mask <= bit_mask >> 2;
      end
      F_DONE: begin
        job.dev  <= dev;
        job.flag <= (dev > cfg.activity_level);
      end
      default: ;
    endcase
  end

  a_root_mask_onehot: assert property (@(posedge clk) disable iff (rst)
    state == F_ROOT |-> $onehot(bit_mask))
    else $error("square root step mask is not a single bit");

endmodule

// ===== sv/acc_ws_queue.sv =====
module acc_ws_queue import acc_ws_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("item pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("item popped from an empty queue");

endmodule

// ===== sv/acc_ws_back.sv =====
module acc_ws_back import acc_ws_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  job_t        head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  mode,
  output logic [15:0] deviation,
  output logic [5:0]  window_active,
  output logic        mode_changed
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_EXEC = 3'b100
  } bstate_t;

  bstate_t          state;
  job_t             job;
  logic [1:0]       cur_mode, mode_next;
  logic [CNT_W-1:0] tally, tally_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic [15:0]      idle_tally, idle_next;
  logic [POS_W-1:0] pos, pos_next;
  logic             flags [WINDOW_LEN];
  logic             old_flag;

  logic             fire, enter, wr_en;
  logic [1:0]       enter_mode;
  logic [POS_W-1:0] wr_addr;
  logic [CNT_W:0]   t_sum;

  assign pop  = (state == B_IDLE) && !empty;
  assign fire = (state == B_EXEC) && (!out_valid || out_ready);

  always_comb begin
    mode_next  = cur_mode;
    tally_next = tally;
    fill_next  = fill;
    idle_next  = idle_tally;
    pos_next   = pos;
    enter      = 1'b0;
    enter_mode = cur_mode;
    wr_en      = 1'b0;
    wr_addr    = pos;
    t_sum      = (CNT_W + 1)'(tally) + (CNT_W + 1)'(job.flag);
    if (job.report) begin
      if (cur_mode == MODE_ACTIVE && job.nonzero) begin
        enter      = 1'b1;
        enter_mode = MODE_READY;
      end else if (cur_mode == MODE_READY && !job.nonzero) begin
        enter      = 1'b1;
        enter_mode = MODE_ACTIVE;
      end
    end else if (cur_mode != MODE_READY) begin
      if (fill != CNT_W'(WINDOW_LEN)) begin
        // Window still filling: store in order, check only on the last slot.
        wr_en      = 1'b1;
        wr_addr    = POS_W'(fill);
        fill_next  = fill + 1'b1;
        tally_next = CNT_W'(t_sum);
        if (fill == CNT_W'(WINDOW_LEN - 1)) begin
          if (cur_mode == MODE_SLEEP) begin
            if (CMP_W'(t_sum) > CMP_W'(cfg.wake_count)) begin
              enter      = 1'b1;
              enter_mode = MODE_ACTIVE;
            end
          end else if (CMP_W'(t_sum) < CMP_W'(cfg.busy_count)) begin
            if (idle_tally != 16'hFFFF) begin
              idle_next = idle_tally + 16'd1;
            end
          end
        end
      end else begin
        // The oldest flag leaves the count only when it was set.
        if (old_flag && t_sum != '0) begin
          t_sum = t_sum - 1'b1;
        end
        tally_next = CNT_W'(t_sum);
        wr_en      = 1'b1;
        pos_next   = (pos == POS_W'(WINDOW_LEN - 1)) ? '0 : pos + 1'b1;
        if (cur_mode == MODE_SLEEP) begin
          if (CMP_W'(t_sum) > CMP_W'(cfg.wake_count)) begin
            enter      = 1'b1;
            enter_mode = MODE_ACTIVE;
          end
        end else begin
          if (CMP_W'(t_sum) < CMP_W'(cfg.busy_count)) begin
            if (idle_tally != 16'hFFFF) begin
              idle_next = idle_tally + 16'd1;
            end
          end else if (idle_tally != 16'd0) begin
            idle_next = idle_tally - 16'd1;
          end
          if (idle_next > cfg.sleep_after) begin
            enter      = 1'b1;
            enter_mode = MODE_SLEEP;
          end
        end
      end
    end
    if (enter) begin
      mode_next  = enter_mode;
      tally_next = '0;
      fill_next  = '0;
      idle_next  = 16'd0;
      pos_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      cur_mode   <= MODE_SLEEP;
      tally      <= '0;
      fill       <= '0;
      idle_tally <= 16'd0;
      pos        <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (!empty) begin
            state <= B_READ;
          end
        end
        B_READ: state <= B_EXEC;
        B_EXEC: begin
          if (fire) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
      if (fire) begin
        cur_mode   <= mode_next;
        tally      <= tally_next;
        fill       <= fill_next;
        idle_tally <= idle_next;
        pos        <= pos_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
    end
    if (fire) begin
      mode          <= mode_next;
      deviation     <= job.dev;
      window_active <= 6'(tally_next);
      mode_changed  <= enter;
    end
  end

  // Every slot is rewritten during the fill phase, so the window needs no clearing.
  always_ff @(posedge clk) begin
    if (fire && wr_en) begin
      flags[wr_addr] <= job.flag;
    end
    old_flag <= flags[pos];
  end

  a_tally_within_fill: assert property (@(posedge clk) disable iff (rst)
    fill != CNT_W'(WINDOW_LEN) |-> tally <= fill)
    else $error("flag count exceeds the filled part of the window");

  a_ready_window_clear: assert property (@(posedge clk) disable iff (rst)
    cur_mode == MODE_READY |-> (tally == '0 && fill == '0))
    else $error("window used while in ready mode");

  a_mode_entry_clears: assert property (@(posedge clk) disable iff (rst)
    fire && enter |=> (fill == '0 && tally == '0 && idle_tally == 16'd0 && pos == '0))
    else $error("mode entry did not clear the window");

endmodule
